### hw/rtl/mvt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the 4x4 matrix-vector transform.
// No dependencies; used by mvt_row and matrix_vector_transform.
package mvt_pkg;

    localparam int DIM      = 4;
    localparam int NREGS    = DIM * 2;
    localparam int Q_W      = 32;
    localparam int Q_FRAC   = 16;
    localparam int REG_W    = 2 * Q_W;
    localparam int CFG_IDX_W = 4;
    localparam int REG_SEL_W = $clog2(NREGS);

    localparam int PROD_W   = 2 * Q_W;
    localparam int SHR_W    = PROD_W - Q_FRAC;
    localparam int PAIR_W   = SHR_W + 1;
    localparam int SUM_W    = PAIR_W + 1;

    localparam logic [REG_W-1:0] ONE_Q16 = REG_W'(64'd65536);

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_ROW0_COLS01 = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW0_COLS23 = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW1_COLS01 = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW1_COLS23 = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROW2_COLS01 = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ROW2_COLS23 = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ROW3_COLS01 = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ROW3_COLS23 = 4'd7;

    typedef logic signed [Q_W-1:0] t_q16;
    typedef logic [DIM-1:0][Q_W-1:0] t_vec;

    typedef struct packed {
        logic signed [Q_W-1:0] in_x;
        logic signed [Q_W-1:0] in_y;
        logic signed [Q_W-1:0] in_z;
        logic signed [Q_W-1:0] in_w;
    } t_in_item;

    typedef struct packed {
        logic signed [Q_W-1:0] out_x;
        logic signed [Q_W-1:0] out_y;
        logic signed [Q_W-1:0] out_z;
        logic signed [Q_W-1:0] out_w;
        logic                  saturated;
    } t_out_item;

    // Per-stage load enables handed to each row datapath
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } t_adv;

    // Identity reset value of one matrix register
    function automatic logic [REG_W-1:0] mat_reset_val(input int idx);
        int row;
        logic [REG_W-1:0] val;
        begin
            row = idx / 2;
            val = '0;
            if ((row >> 1) == (idx & 1)) begin
                val = ONE_Q16 << (Q_W * (row & 1));
            end
            return val;
        end
    endfunction

endpackage

### hw/rtl/mvt_row.sv
`timescale 1ns / 1ps
// One row of the transform: four products, adder tree, saturation.
// Depends on mvt_pkg; stage enables come from matrix_vector_transform.
module mvt_row
    import mvt_pkg::*;
(
    input  logic          i_clk,
    input  t_adv          i_adv,
    input  t_vec          i_elem,
    input  t_vec          i_vec,
    output logic [Q_W-1:0] o_value,
    output logic          o_sat
);

    localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(64'sh7FFF_FFFF);
    localparam logic signed [SUM_W-1:0] SAT_MIN = -SUM_W'(64'sh8000_0000);

    logic signed [PROD_W-1:0] r_prod [DIM];
    logic signed [PAIR_W-1:0] r_pair [DIM/2];
    logic signed [SUM_W-1:0]  r_sum;
    logic [Q_W-1:0]           r_value;
    logic                     r_sat;

    logic signed [PAIR_W-1:0] n_pair [DIM/2];
    logic signed [SUM_W-1:0]  n_sum;
    logic [Q_W-1:0]           n_value;
    logic                     n_sat;

    // Stage 1: full signed products
    always_ff @(posedge i_clk) begin
        if (i_adv.s1) begin
            for (int c = 0; c < DIM; c++) begin
                r_prod[c] <= $signed(i_elem[c]) * $signed(i_vec[c]);
            end
        end
    end

    // Stage 2: drop fraction bits (floor) and add pairs
    always_comb begin
        for (int k = 0; k < DIM/2; k++) begin
            n_pair[k] = PAIR_W'($signed(r_prod[2*k][PROD_W-1:Q_FRAC]))
                      + PAIR_W'($signed(r_prod[2*k+1][PROD_W-1:Q_FRAC]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv.s2) begin
            r_pair <= n_pair;
        end
    end

    // Stage 3: row sum
    assign n_sum = SUM_W'(r_pair[0]) + SUM_W'(r_pair[1]);

    always_ff @(posedge i_clk) begin
        if (i_adv.s3) begin
            r_sum <= n_sum;
        end
    end

    // Stage 4: clamp to 32 bits
    always_comb begin
        n_value = r_sum[Q_W-1:0];
        n_sat   = 1'b0;
        if (r_sum > SAT_MAX) begin
            n_value = {1'b0, {(Q_W-1){1'b1}}};
            n_sat   = 1'b1;
        end else if (r_sum < SAT_MIN) begin
            n_value = {1'b1, {(Q_W-1){1'b0}}};
            n_sat   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv.s4) begin
            r_value <= n_value;
            r_sat   <= n_sat;
        end
    end

    assign o_value = r_value;
    assign o_sat   = r_sat;

endmodule

### hw/rtl/matrix_vector_transform.sv
`timescale 1ns / 1ps
// 4x4 signed Q16.16 matrix times vector, four-stage pipeline.
// Depends on mvt_pkg and mvt_row.
//
// Usage:
//   Input channel i_valid / i_data / o_stall carries one vector (x, y, z, w)
//   per transaction; output channel o_valid / o_data / i_stall returns the
//   four transformed components and a saturation flag, one per input.
//   The matrix sits in eight 64-bit registers written through
//   i_cfg_we / i_cfg_idx / i_cfg_data; indexes beyond the eighth are
//   ignored. Write them only while the pipeline is empty.
//   A result reaches o_valid through four register stages: multiply, floor
//   shift and pair add, row sum, saturate into the output register.
//   Throughput is one vector per cycle while the receiver does not stall;
//   the 16 32x32 multipliers of stage one set the critical path.
//   Reset (synchronous, active low) empties the pipeline and loads the
//   identity matrix.
//   When the receiver stalls, the result holds in the output register and
//   earlier stages keep filling until each holds a transaction; only then
//   does o_stall rise. Nothing is dropped or repeated.
module matrix_vector_transform
    import mvt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  t_in_item             i_data,
    output logic                 o_stall,
    output logic                 o_valid,
    output t_out_item            o_data,
    input  logic                 i_stall,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [REG_W-1:0]     i_cfg_data
);

    logic [REG_W-1:0] r_mat [NREGS];
    logic [3:0]       r_vld;          // stage valid bits, bit 3 is the output
    logic [3:0]       n_vld;
    logic [3:0]       w_rdy;
    t_adv             w_adv;
    t_vec             w_vec;
    t_vec             w_elem [DIM];
    logic [Q_W-1:0]   w_val  [DIM];
    logic [DIM-1:0]   w_sat;

    // Matrix registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NREGS; i++) begin
                r_mat[i] <= mat_reset_val(i);
            end
        end else if (i_cfg_we && (i_cfg_idx < CFG_IDX_W'(NREGS))) begin
            r_mat[i_cfg_idx[REG_SEL_W-1:0]] <= i_cfg_data;
        end
    end

    // Stage handshake: a stage loads when it is empty or its content moves on
    assign w_rdy[3] = !r_vld[3] || !i_stall;
    assign w_rdy[2] = !r_vld[2] || w_rdy[3];
    assign w_rdy[1] = !r_vld[1] || w_rdy[2];
    assign w_rdy[0] = !r_vld[0] || w_rdy[1];

    assign w_adv.s1 = w_rdy[0];
    assign w_adv.s2 = w_rdy[1];
    assign w_adv.s3 = w_rdy[2];
    assign w_adv.s4 = w_rdy[3];

    assign n_vld[0] = w_rdy[0] ? i_valid  : r_vld[0];
    assign n_vld[1] = w_rdy[1] ? r_vld[0] : r_vld[1];
    assign n_vld[2] = w_rdy[2] ? r_vld[1] : r_vld[2];
    assign n_vld[3] = w_rdy[3] ? r_vld[2] : r_vld[3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign w_vec[0] = i_data.in_x;
    assign w_vec[1] = i_data.in_y;
    assign w_vec[2] = i_data.in_z;
    assign w_vec[3] = i_data.in_w;

    genvar gr, gc;
    generate
        for (gr = 0; gr < DIM; gr++) begin : g_row
            for (gc = 0; gc < DIM; gc++) begin : g_col
                localparam int RIDX = gr * 2 + gc / 2;
                localparam int HALF = gc % 2;
                assign w_elem[gr][gc] = r_mat[RIDX][HALF*Q_W +: Q_W];
            end

            mvt_row u_row (
                .i_clk   (i_clk),
                .i_adv   (w_adv),
                .i_elem  (w_elem[gr]),
                .i_vec   (w_vec),
                .o_value (w_val[gr]),
                .o_sat   (w_sat[gr])
            );
        end
    endgenerate

    assign o_stall          = !w_rdy[0];
    assign o_valid          = r_vld[3];
    assign o_data.out_x     = w_val[0];
    assign o_data.out_y     = w_val[1];
    assign o_data.out_z     = w_val[2];
    assign o_data.out_w     = w_val[3];
    assign o_data.saturated = |w_sat;

endmodule
